@@ sv/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for greedy box suppression
// Box record layout, widths of the overlap arithmetic and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

    // Set capacity and index widths.
    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;

    // Field and arithmetic widths.
    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 2;
    localparam int THR_W   = 17;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int PROD_W  = THR_W + UNI_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(22938);

    // One stored box.
    typedef struct packed {
        logic [CLASS_W-1:0] class_label;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] bottom_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] left_x;
    } box_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_R_I,
        ST_R_IL,
        ST_R_J,
        ST_R_JC,
        ST_W_SEL,
        ST_W_EMIT,
        ST_W_RK,
        ST_W_BX,
        ST_Q_SEL,
        ST_Q_RK,
        ST_Q_BX,
        ST_OV_W,
        ST_OV_IA,
        ST_OV_AB,
        ST_OV_UN,
        ST_OV_TU,
        ST_OV_CMP,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

@@ sv/greedy_box_nms.sv @@
// ----------------------------------------------------------------------------
// greedy_box_nms: greedy non-maximum suppression by intersection over union
// Loads a set of boxes, ranks them by score and emits the surviving boxes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one box per cycle while the
//   block is loading. A box with last_box set closes the set; boxes beyond
//   MAX_BOXES are dropped, but their last_box still closes the set.
//   The block then stalls its input while it ranks and suppresses. Ranking
//   counts, for each box, the boxes that outrank it using one score
//   comparator. The walk then tests each pair of surviving boxes with one
//   shared 17x33 multiplier, taking a shorter path for a disjoint pair than
//   for an overlapping one. Kept boxes leave on the output channel
//   (out_valid / out_stall) in ranked order; last_kept marks the final
//   one. A stalled kept box waits in the output register; the sequencer
//   goes on testing pairs and pauses only when the next kept box is
//   ready. The threshold is written through cfg_write_en and cfg_write_data
//   while the block is idle, a rule on the user that the block does not enforce.
//   Reset empties the set, clears all suppression marks and restores the
//   threshold to 22938 (about 0.35).
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_nms
    import gbn_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write_en,
    input  wire logic [THR_W-1:0]   cfg_write_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COORD_W-1:0] left_x,
    input  wire logic [COORD_W-1:0] top_y,
    input  wire logic [COORD_W-1:0] right_x,
    input  wire logic [COORD_W-1:0] bottom_y,
    input  wire logic [SCORE_W-1:0] score,
    input  wire logic [CLASS_W-1:0] class_label,
    input  wire logic               last_box,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COORD_W-1:0]      out_left,
    output logic [COORD_W-1:0]      out_top,
    output logic [COORD_W-1:0]      out_right,
    output logic [COORD_W-1:0]      out_bottom,
    output logic [SCORE_W-1:0]      out_score,
    output logic [CLASS_W-1:0]      out_class,
    output logic [IDX_W-1:0]        arrival_index,
    output logic                    last_kept
);

    // Storage.
    box_t             box_mem [MAX_BOXES];
    logic [IDX_W-1:0] rank_mem [MAX_BOXES];
    box_t             box_rd_reg;
    logic [IDX_W-1:0] rank_rd_reg;

    state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   i_reg, j_reg, p_reg, q_reg;
    logic [IDX_W-1:0]   rank_cnt_reg;
    logic [SCORE_W-1:0] score_i_reg;
    logic [MAX_BOXES-1:0] supp_reg;
    logic               pend_valid_reg;

    box_t             a_box_reg, b_box_reg;
    logic [IDX_W-1:0] a_idx_reg;

    logic [AREA_W-1:0] inter_reg, sum_reg;
    logic [UNI_W-1:0]  uni_reg;
    logic [PROD_W-1:0] prod_reg;

    logic out_valid_reg, out_last_reg;
    box_t out_box_reg;
    logic [IDX_W-1:0] out_idx_reg;

    // Handshake helpers.
    logic in_xfer, store_box, out_free;
    logic [CNT_W-1:0] count_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign store_box = in_xfer && (count_reg < CNT_W'(MAX_BOXES));
    assign count_inc = count_reg + CNT_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;

    // Overlap geometry of the current pair.
    logic [COORD_W-1:0] il, it, ir, ib, ov_w, ov_h;
    logic overlap_pos;

    always_comb
    begin
        il = (a_box_reg.left_x > b_box_reg.left_x) ? a_box_reg.left_x : b_box_reg.left_x;
        it = (a_box_reg.top_y > b_box_reg.top_y) ? a_box_reg.top_y : b_box_reg.top_y;
        ir = (a_box_reg.right_x < b_box_reg.right_x) ? a_box_reg.right_x : b_box_reg.right_x;
        ib = (a_box_reg.bottom_y < b_box_reg.bottom_y) ? a_box_reg.bottom_y
                                                       : b_box_reg.bottom_y;
        overlap_pos = (ir > il) && (ib > it);
        ov_w = ir - il;
        ov_h = ib - it;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && last_box)
                    state_next = ST_R_I;
            end
            ST_R_I:    state_next = (i_reg == count_reg) ? ST_W_SEL : ST_R_IL;
            ST_R_IL:   state_next = ST_R_J;
            ST_R_J:    state_next = (j_reg == count_reg) ? ST_R_I : ST_R_JC;
            ST_R_JC:   state_next = ST_R_J;
            ST_W_SEL:
            begin
                priority if (p_reg == count_reg)
                    state_next = ST_FIN;
                else if (!supp_reg[p_reg[IDX_W-1:0]])
                    state_next = ST_W_EMIT;
            end
            ST_W_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_W_RK;
            end
            ST_W_RK:   state_next = ST_W_BX;
            ST_W_BX:   state_next = ST_Q_SEL;
            ST_Q_SEL:
            begin
                priority if (q_reg == count_reg)
                    state_next = ST_W_SEL;
                else if (!supp_reg[q_reg[IDX_W-1:0]])
                    state_next = ST_Q_RK;
            end
            ST_Q_RK:   state_next = ST_Q_BX;
            ST_Q_BX:   state_next = ST_OV_W;
            ST_OV_W:   state_next = overlap_pos ? ST_OV_IA : ST_Q_SEL;
            ST_OV_IA:  state_next = ST_OV_AB;
            ST_OV_AB:  state_next = ST_OV_UN;
            ST_OV_UN:  state_next = ST_OV_TU;
            ST_OV_TU:  state_next = ST_OV_CMP;
            ST_OV_CMP: state_next = ST_Q_SEL;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory addresses, multiplier operands, output load.
    logic [IDX_W-1:0] box_raddr, rank_raddr;
    logic [THR_W-1:0] mul_a;
    logic [UNI_W-1:0] mul_b;
    logic             out_load, out_load_last;

    always_comb
    begin
        box_raddr     = i_reg[IDX_W-1:0];
        rank_raddr    = p_reg[IDX_W-1:0];
        mul_a         = '0;
        mul_b         = '0;
        out_load      = 1'b0;
        out_load_last = 1'b0;
        unique case (state_reg)
            ST_R_J:    box_raddr = j_reg[IDX_W-1:0];
            ST_W_RK:   box_raddr = rank_rd_reg;
            ST_Q_SEL:  rank_raddr = q_reg[IDX_W-1:0];
            ST_Q_RK:   box_raddr = rank_rd_reg;
            ST_W_EMIT: out_load = pend_valid_reg && out_free;
            ST_FIN:
            begin
                out_load      = out_free;
                out_load_last = 1'b1;
            end
            ST_OV_W:
            begin
                mul_a = THR_W'(ov_w);
                mul_b = UNI_W'(ov_h);
            end
            ST_OV_IA:
            begin
                mul_a = THR_W'(a_box_reg.right_x - a_box_reg.left_x);
                mul_b = UNI_W'(a_box_reg.bottom_y - a_box_reg.top_y);
            end
            ST_OV_AB:
            begin
                mul_a = THR_W'(b_box_reg.right_x - b_box_reg.left_x);
                mul_b = UNI_W'(b_box_reg.bottom_y - b_box_reg.top_y);
            end
            ST_OV_TU:
            begin
                mul_a = thr_reg;
                mul_b = uni_reg;
            end
            default:
            begin
                box_raddr = i_reg[IDX_W-1:0];
            end
        endcase
    end

    // Box and rank memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (store_box)
            box_mem[count_reg[IDX_W-1:0]] <= '{class_label: class_label, score: score,
                                               bottom_y: bottom_y, right_x: right_x,
                                               top_y: top_y, left_x: left_x};
        if (state_reg == ST_R_J && j_reg == count_reg)
            rank_mem[rank_cnt_reg] <= i_reg[IDX_W-1:0];
        box_rd_reg  <= box_mem[box_raddr];
        rank_rd_reg <= rank_mem[rank_raddr];
    end

    // Shared multiplier and pair datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (state_reg == ST_R_IL)
            score_i_reg <= box_rd_reg.score;
        if (state_reg == ST_W_RK)
            a_idx_reg <= rank_rd_reg;
        if (state_reg == ST_W_BX)
            a_box_reg <= box_rd_reg;
        if (state_reg == ST_Q_BX)
            b_box_reg <= box_rd_reg;
        if (state_reg == ST_OV_IA)
            inter_reg <= prod_reg[AREA_W-1:0];
        if (state_reg == ST_OV_AB)
            sum_reg <= prod_reg[AREA_W-1:0];
        if (state_reg == ST_OV_UN)
            uni_reg <= UNI_W'(sum_reg) + UNI_W'(prod_reg[AREA_W-1:0]) - UNI_W'(inter_reg);
        if (out_load)
        begin
            out_box_reg <= a_box_reg;
            out_idx_reg <= a_idx_reg;
            out_last_reg <= out_load_last;
        end
    end

    // Control registers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            p_reg          <= '0;
            q_reg          <= '0;
            rank_cnt_reg   <= '0;
            supp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
                thr_reg <= cfg_write_data;

            // Output register: a load wins over a completed transfer.
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (store_box)
                        count_reg <= count_inc;
                    i_reg <= '0;
                end
                ST_R_I:
                begin
                    j_reg        <= '0;
                    rank_cnt_reg <= '0;
                    p_reg        <= '0;
                end
                ST_R_J:
                begin
                    if (j_reg == count_reg)
                        i_reg <= i_reg + CNT_W'(1);
                end
                ST_R_JC:
                begin
                    if ((box_rd_reg.score > score_i_reg) ||
                        (box_rd_reg.score == score_i_reg && j_reg < i_reg))
                        rank_cnt_reg <= rank_cnt_reg + IDX_W'(1);
                    j_reg <= j_reg + CNT_W'(1);
                end
                ST_W_SEL:
                begin
                    if (p_reg != count_reg && supp_reg[p_reg[IDX_W-1:0]])
                        p_reg <= p_reg + CNT_W'(1);
                end
                ST_W_BX:
                begin
                    pend_valid_reg <= 1'b1;
                    q_reg          <= p_reg + CNT_W'(1);
                end
                ST_Q_SEL:
                begin
                    priority if (q_reg == count_reg)
                        p_reg <= p_reg + CNT_W'(1);
                    else if (supp_reg[q_reg[IDX_W-1:0]])
                        q_reg <= q_reg + CNT_W'(1);
                end
                ST_OV_W:
                begin
                    if (!overlap_pos)
                    begin
                        supp_reg[q_reg[IDX_W-1:0]] <= (thr_reg == '0);
                        q_reg <= q_reg + CNT_W'(1);
                    end
                end
                ST_OV_CMP:
                begin
                    supp_reg[q_reg[IDX_W-1:0]] <=
                        ({2'b00, inter_reg, 16'h0000} >= prod_reg);
                    q_reg <= q_reg + CNT_W'(1);
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        supp_reg       <= '0;
                        count_reg      <= '0;
                        pend_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Result ports.
    assign out_valid     = out_valid_reg;
    assign out_left      = out_box_reg.left_x;
    assign out_top       = out_box_reg.top_y;
    assign out_right     = out_box_reg.right_x;
    assign out_bottom    = out_box_reg.bottom_y;
    assign out_score     = out_box_reg.score;
    assign out_class     = out_box_reg.class_label;
    assign arrival_index = out_idx_reg;
    assign last_kept     = out_last_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for greedy box suppression
// Streams sets of boxes into the block, predicts the kept boxes for each set
// by ranking and overlap suppression, and compares every kept box that leaves
// the block with the oldest prediction. The threshold is varied between sets.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import gbn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted or observed kept box transfer.
    typedef struct packed {
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic [15:0] score;
        logic [1:0]  class_label;
        logic [5:0]  index;
        logic        last;
    } kept_t;

    // Scoreboard: holds the open set, the threshold and the predicted kept boxes.
    class nms_scoreboard;
        gbn_pkg::box_t open_set[$];
        kept_t         kept_q[$];
        logic [16:0]   threshold;
        int            errors;
        int            kept_seen;
        int            sets_closed;

        function void clear_all();
            open_set.delete();
            kept_q.delete();
            threshold   = gbn_pkg::THR_RESET;
            errors      = 0;
            kept_seen   = 0;
            sets_closed = 0;
        endfunction

        // True when box b should be suppressed by the kept box a.
        function bit suppresses(gbn_pkg::box_t a, gbn_pkg::box_t b);
            longint il, it, ir, ib, w, h;
            longint unsigned inter, area_a, area_b, uni;
            il = (a.left_x > b.left_x) ? a.left_x : b.left_x;
            it = (a.top_y > b.top_y) ? a.top_y : b.top_y;
            ir = (a.right_x < b.right_x) ? a.right_x : b.right_x;
            ib = (a.bottom_y < b.bottom_y) ? a.bottom_y : b.bottom_y;
            w = ir - il;
            h = ib - it;
            if (w <= 0 || h <= 0)
                return threshold == 0;
            inter  = w * h;
            area_a = longint'(a.right_x - a.left_x) * longint'(a.bottom_y - a.top_y);
            area_b = longint'(b.right_x - b.left_x) * longint'(b.bottom_y - b.top_y);
            uni    = area_a + area_b - inter;
            return (inter * 65536) >= (longint'(threshold) * uni);
        endfunction

        // Note one accepted box; a closing box triggers the prediction.
        function void note_box(gbn_pkg::box_t b, bit last);
            int    n, i, j, cur, last_pos;
            int    order[64];
            bit    gone[64];
            kept_t k;
            if (open_set.size() < gbn_pkg::MAX_BOXES)
                open_set.insert(open_set.size(), b);
            if (!last)
                return;
            n = open_set.size();
            // Stable descending rank by score.
            for (i = 0; i < n; i++) begin
                cur = i;
                j = i;
                while (j > 0 && open_set[order[j-1]].score < open_set[cur].score) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
                gone[i] = 0;
            end
            last_pos = -1;
            for (i = 0; i < n; i++) begin
                if (!gone[order[i]]) begin
                    k.left_x      = open_set[order[i]].left_x;
                    k.top_y       = open_set[order[i]].top_y;
                    k.right_x     = open_set[order[i]].right_x;
                    k.bottom_y    = open_set[order[i]].bottom_y;
                    k.score       = open_set[order[i]].score;
                    k.class_label = open_set[order[i]].class_label;
                    k.index       = order[i][5:0];
                    k.last        = 0;
                    kept_q.insert(kept_q.size(), k);
                    last_pos = kept_q.size() - 1;
                    for (j = i + 1; j < n; j++)
                        if (!gone[order[j]] &&
                            suppresses(open_set[order[i]], open_set[order[j]]))
                            gone[order[j]] = 1;
                end
            end
            kept_q[last_pos].last = 1;
            open_set.delete();
            sets_closed++;
        endfunction

        function void field_check(string name, longint unsigned exp_v,
                                  longint unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one kept box transfer against the oldest prediction.
        function void check_kept(kept_t act);
            kept_t e;
            if (kept_q.size() == 0) begin
                $display("%0t: unexpected kept box, index %0d", $time, act.index);
                errors++;
                return;
            end
            e = kept_q.pop_front();
            kept_seen++;
            field_check("out_left", e.left_x, act.left_x);
            field_check("out_top", e.top_y, act.top_y);
            field_check("out_right", e.right_x, act.right_x);
            field_check("out_bottom", e.bottom_y, act.bottom_y);
            field_check("out_score", e.score, act.score);
            field_check("out_class", e.class_label, act.class_label);
            field_check("arrival_index", e.index, act.index);
            field_check("last_kept", e.last, act.last);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic [THR_W-1:0]   cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [COORD_W-1:0] left_x, top_y, right_x, bottom_y;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_label;
    logic               last_box;
    logic               out_valid;
    logic               out_stall;
    logic [COORD_W-1:0] out_left, out_top, out_right, out_bottom;
    logic [SCORE_W-1:0] out_score;
    logic [CLASS_W-1:0] out_class;
    logic [IDX_W-1:0]   arrival_index;
    logic               last_kept;

    nms_scoreboard sb;
    bit            quiet;
    int            hold_req_cnt;
    int            boxes_sent;
    int            thr_writes;

    greedy_box_nms dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_x(left_x), .top_y(top_y), .right_x(right_x), .bottom_y(bottom_y),
        .score(score), .class_label(class_label), .last_box(last_box),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_left(out_left), .out_top(out_top), .out_right(out_right),
        .out_bottom(out_bottom), .out_score(out_score), .out_class(out_class),
        .arrival_index(arrival_index), .last_kept(last_kept)
    );

    always #10 clk = ~clk;

    // Hard limit on run time.
    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: checks kept box transfers and stalls in bursts or long holds.
    // A requested long hold starts at the first kept box offered after it.
    initial
    begin
        int burst;
        int hold;
        int hold_done;
        kept_t act;
        burst = 0;
        hold = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                act = {out_left, out_top, out_right, out_bottom, out_score,
                       out_class, arrival_index, last_kept};
                sb.check_kept(act);
            end
            if (hold_req_cnt != hold_done && out_valid) begin
                hold_done = hold_req_cnt;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // One box transfer, with an optional idle burst in front of it.
    task automatic send_box(box_t b, bit last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        left_x      <= b.left_x;
        top_y       <= b.top_y;
        right_x     <= b.right_x;
        bottom_y    <= b.bottom_y;
        score       <= b.score;
        class_label <= b.class_label;
        last_box    <= last;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_box(b, last);
        boxes_sent++;
    endtask

    // Wait until all kept boxes arrived and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.kept_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.threshold = v;
        thr_writes++;
    endtask

    function automatic box_t make_box(int cx, int cy, bit noise);
        box_t        b;
        int          w, h, l, t;
        logic [95:0] raw;
        if (noise) begin
            raw = {$urandom, $urandom, $urandom};
            b = raw[$bits(box_t)-1:0];
            return b;
        end
        l = cx + $urandom_range(0, 600);
        t = cy + $urandom_range(0, 600);
        w = $urandom_range(0, 6000);
        h = $urandom_range(0, 6000);
        b.left_x      = 16'(l);
        b.top_y       = 16'(t);
        b.right_x     = 16'((l + w > 65535) ? 65535 : l + w);
        b.bottom_y    = 16'((t + h > 65535) ? 65535 : t + h);
        b.score       = 16'($urandom);
        b.class_label = 2'($urandom_range(0, 3));
        return b;
    endfunction

    // Random set of n boxes in a few clusters, with ties and stray boxes.
    task automatic send_set(int n);
        box_t b;
        int   cx, cy;
        logic [15:0] prev_score;
        prev_score = 16'($urandom);
        cx = $urandom_range(0, 58000);
        cy = $urandom_range(0, 58000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                cx = $urandom_range(0, 58000);
                cy = $urandom_range(0, 58000);
            end
            b = make_box(cx, cy, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) == 0)
                b.score = prev_score;
            prev_score = b.score;
            send_box(b, i == n - 1);
        end
    endtask

    // Main sequence: reset, directed sets, then random sets.
    initial
    begin
        box_t b;
        int   set_no;
        logic [THR_W-1:0] thr_pick;
        sb = new();
        sb.clear_all();
        clk = 0;
        rst_n = 0;
        cfg_write_en = 0;
        cfg_write_data = '0;
        in_valid = 0;
        {left_x, top_y, right_x, bottom_y, score, class_label, last_box} = '0;
        quiet = 0;
        hold_req_cnt = 0;
        boxes_sent = 0;
        thr_writes = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-frame box alone, at reset threshold.
        b = '{class_label: 2'd3, score: 16'hFFFF, bottom_y: 16'hFFFF,
              right_x: 16'hFFFF, top_y: 16'h0, left_x: 16'h0};
        send_box(b, 1);
        drain();

        // Duplicates, equal scores, inverted and empty boxes.
        b = '{class_label: 2'd0, score: 16'd100, bottom_y: 16'd2000,
              right_x: 16'd2000, top_y: 16'd1000, left_x: 16'd1000};
        send_box(b, 0);
        send_box(b, 0);
        b.class_label = 2'd1;
        send_box(b, 0);
        b = '{class_label: 2'd2, score: 16'd500, bottom_y: 16'd10,
              right_x: 16'd10, top_y: 16'd900, left_x: 16'd900};
        send_box(b, 0);
        b = '{class_label: 2'd3, score: 16'd0, bottom_y: 16'd50,
              right_x: 16'd50, top_y: 16'd50, left_x: 16'd50};
        send_box(b, 0);
        b = '{class_label: 2'd1, score: 16'd300, bottom_y: 16'd2100,
              right_x: 16'd2100, top_y: 16'd1100, left_x: 16'd1100};
        send_box(b, 1);
        drain();

        // Zero threshold: disjoint boxes are suppressed too.
        write_threshold(17'd0);
        for (int i = 0; i < 5; i++) begin
            b = '{class_label: i[1:0], score: 16'(1000 * i), bottom_y: 16'(i * 5000 + 100),
                  right_x: 16'(i * 5000 + 100), top_y: 16'(i * 5000), left_x: 16'(i * 5000)};
            send_box(b, i == 4);
        end
        drain();

        // Exactly 1.0: only identical boxes are suppressed.
        write_threshold(17'd65536);
        b = '{class_label: 2'd2, score: 16'd7, bottom_y: 16'd4000,
              right_x: 16'd4000, top_y: 16'd3000, left_x: 16'd3000};
        send_box(b, 0);
        send_box(b, 0);
        b.right_x = 16'd4001;
        send_box(b, 1);
        drain();

        // Above 1.0: nothing is suppressed.
        write_threshold(17'h1FFFF);
        b.right_x = 16'd4000;
        send_box(b, 0);
        send_box(b, 1);
        drain();
        write_threshold(THR_RESET);

        // Random sets: mostly small, some full, one that overflows.
        set_no = 0;
        while (boxes_sent < 280) begin
            if (boxes_sent > 245)
                quiet = 1;
            if (set_no == 2) begin
                send_set(64);
                hold_req_cnt++;
            end else if (set_no == 5)
                send_set(70);
            else if (set_no == 8)
                send_set(64);
            else
                send_set($urandom_range(1, 12));
            // The next set is offered while the receiver may still be held.
            if (set_no != 2 && $urandom_range(0, 2) == 0) begin
                drain();
                case ($urandom_range(0, 4))
                    0: thr_pick = 17'd0;
                    1: thr_pick = 17'd65536;
                    2: thr_pick = 17'h1FFFF;
                    default: thr_pick = 17'($urandom_range(0, 65536));
                endcase
                write_threshold(thr_pick);
            end
            set_no++;
        end
        drain();
        repeat (100) @(posedge clk);

        $display("Run covered %0d boxes in %0d sets, %0d kept boxes checked, %0d threshold writes.",
                 boxes_sent, sb.sets_closed, sb.kept_seen, thr_writes);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
sv/gbn_pkg.sv
sv/greedy_box_nms.sv
tb/tb_top.sv
